/* rtl/thermostat_setpoint_controller_defines.svh */
// assertion helpers shared by the rtl
`ifndef THERMOSTAT_SETPOINT_CONTROLLER_DEFINES_SVH
`define THERMOSTAT_SETPOINT_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsc assertion failed");

// next-cycle implication, checked outside reset
`define TSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsc assertion failed");

`endif

/* rtl/tsc_pkg.sv */
`default_nettype none
package tsc_pkg;

  // field widths
  localparam int unsigned TempRawW = 11;
  localparam int unsigned ValW     = 8;
  localparam int unsigned CfgIdxW  = 2;

  // reset values
  localparam logic [ValW-1:0] UpperLimitRst = 8'd100;
  localparam logic [ValW-1:0] LowerLimitRst = 8'd40;
  localparam logic [ValW-1:0] HighSetRst    = 8'd100;
  localparam logic [ValW-1:0] LowSetRst     = 8'd40;

  // temperature conversion: floor(n / 5) = (n * 52429) >> 18 for n below 2^16
  localparam logic [15:0] Div5Recip   = 16'd52429;
  localparam int unsigned Div5Shift   = 18;
  localparam logic [8:0]  FahrOffset  = 9'd32;
  localparam logic [8:0]  FahrMax     = 9'd255;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_UPPER_LIMIT = 2'd0,
    CFG_LOWER_LIMIT = 2'd1
  } cfg_idx_t;

  // input item
  typedef struct packed {
    logic                enc_a;
    logic                enc_b;
    logic                low_button;
    logic                high_button;
    logic [TempRawW-1:0] temp_raw;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [ValW-1:0] temp_fahrenheit;
    logic [ValW-1:0] high_value;
    logic [ValW-1:0] low_value;
    logic            cool_on;
    logic            heat_on;
    logic            adjusting_high;
  } out_item_t;

  // control into the setpoint unit
  typedef struct packed {
    logic commit;
    logic enc_a;
    logic enc_b;
    logic low_button;
    logic high_button;
  } sp_ctl_t;

  // setpoints after the current sample
  typedef struct packed {
    logic [ValW-1:0] high_value;
    logic [ValW-1:0] low_value;
    logic            adjusting_high;
  } sp_val_t;

endpackage
`default_nettype wire

/* rtl/tsc_temp.sv */
`default_nettype none
module tsc_temp (
  input  wire logic [tsc_pkg::TempRawW-1:0] temp_raw,
  input  wire logic [tsc_pkg::ValW-1:0]     high_value,
  input  wire logic [tsc_pkg::ValW-1:0]     low_value,
  output logic      [tsc_pkg::ValW-1:0]     temp_fahrenheit,
  output logic                              cool_on,
  output logic                              heat_on
);

  logic [14:0] times9;
  logic [10:0] div16;
  logic [26:0] prod;
  logic [8:0]  quot;
  logic [8:0]  fahr;

  // 9 * raw / 80 = (9 * raw / 16) / 5
  assign times9 = {1'b0, temp_raw, 3'b000} + {4'b0000, temp_raw};
  assign div16  = times9[14:4];
  assign prod   = {16'd0, div16} * {11'd0, tsc_pkg::Div5Recip};
  assign quot   = prod[tsc_pkg::Div5Shift +: 9];
  assign fahr   = quot + tsc_pkg::FahrOffset;

  // saturate to eight bits
  assign temp_fahrenheit = (fahr > tsc_pkg::FahrMax) ? 8'hFF : fahr[7:0];

  // bang-bang demands against the updated setpoints
  assign cool_on = high_value < temp_fahrenheit;
  assign heat_on = low_value > temp_fahrenheit;

endmodule
`default_nettype wire

/* rtl/tsc_setpoint.sv */
`default_nettype none
module tsc_setpoint (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tsc_pkg::sp_ctl_t          ctl,
  input  wire logic [tsc_pkg::ValW-1:0]  upper_limit,
  input  wire logic [tsc_pkg::ValW-1:0]  lower_limit,
  output tsc_pkg::sp_val_t               val
);

  `include "thermostat_setpoint_controller_defines.svh"

  logic [1:0]                phase_r, phase_nxt;
  logic [tsc_pkg::ValW-1:0]  high_r, high_nxt;
  logic [tsc_pkg::ValW-1:0]  low_r, low_nxt;
  logic                      sel_high_r, sel_high_nxt;

  logic [1:0]        pin_phase;
  logic              step_up;
  logic              step_dn;
  logic signed [9:0] step;
  logic signed [9:0] hv;
  logic signed [9:0] lv;

  // pin levels to phase: 00->0, 10->1, 11->2, 01->3
  assign pin_phase = {ctl.enc_b, ctl.enc_a ^ ctl.enc_b};
  assign step_up   = pin_phase == (phase_r + 2'd1);
  assign step_dn   = pin_phase == (phase_r - 2'd1);
  assign step      = step_up ? 10'sd1 : (step_dn ? -10'sd1 : 10'sd0);

  // button select, low wins
  always_comb begin
    if (!ctl.low_button) begin
      sel_high_nxt = 1'b0;
    end else if (!ctl.high_button) begin
      sel_high_nxt = 1'b1;
    end else begin
      sel_high_nxt = sel_high_r;
    end
  end

  // clamped step of the selected setpoint
  always_comb begin
    hv = $signed({2'b00, high_r}) + step;
    if (hv > $signed({2'b00, upper_limit})) begin
      hv = $signed({2'b00, upper_limit});
    end
    if (hv < $signed({2'b00, low_r})) begin
      hv = $signed({2'b00, low_r});
    end
    lv = $signed({2'b00, low_r}) + step;
    if (lv < $signed({2'b00, lower_limit})) begin
      lv = $signed({2'b00, lower_limit});
    end
    if (lv > $signed({2'b00, high_r})) begin
      lv = $signed({2'b00, high_r});
    end
    phase_nxt = phase_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    if (step_up || step_dn) begin
      phase_nxt = pin_phase;
      if (sel_high_nxt) begin
        high_nxt = hv[7:0];
      end else begin
        low_nxt = lv[7:0];
      end
    end
  end

  assign val.high_value     = high_nxt;
  assign val.low_value      = low_nxt;
  assign val.adjusting_high = sel_high_nxt;

  // state update once per sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 2'd0;
      high_r     <= tsc_pkg::HighSetRst;
      low_r      <= tsc_pkg::LowSetRst;
      sel_high_r <= 1'b1;
    end else if (ctl.commit) begin
      phase_r    <= phase_nxt;
      high_r     <= high_nxt;
      low_r      <= low_nxt;
      sel_high_r <= sel_high_nxt;
    end
  end

  // setpoints never cross
  `TSC_ASSERT_IMP(a_order, 1'b1, low_r <= high_r)
  // state holds between samples
  `TSC_ASSERT_NXT(a_hold, !ctl.commit, $stable(high_r) && $stable(low_r) && $stable(phase_r))
  // phase moves by at most one step
  `TSC_ASSERT_NXT(a_phase, ctl.commit, (phase_r - $past(phase_r)) != 2'd2)
  // a setpoint only changes on an encoder step
  `TSC_ASSERT_NXT(a_move, ctl.commit && !step_up && !step_dn, $stable(high_r) && $stable(low_r))

endmodule
`default_nettype wire

/* rtl/thermostat_setpoint_controller.sv */
`default_nettype none
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_data  (tsc_pkg::in_item_t)
// out     | output    | out_valid / out_ready  | out_data (tsc_pkg::out_item_t)
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one sample per clock sustained while out_ready is high; a sample passes
// from the input register into the result register before it transfers out
// synchronous active-low reset restores setpoints 100/40, limits 100/40,
// phase 0 and high selected; cfg_ready is always high
// a stalled output holds its result; the input register still takes a sample
// while the result register waits, and in_ready drops only when both are full
// and out_ready is low
module thermostat_setpoint_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire tsc_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tsc_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tsc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [tsc_pkg::ValW-1:0]      cfg_data
);

  `include "thermostat_setpoint_controller_defines.svh"

  logic                      s1_valid_r;
  tsc_pkg::in_item_t         s1_data_r;
  logic                      out_valid_r;
  tsc_pkg::out_item_t        out_data_r, out_data_nxt;
  logic [tsc_pkg::ValW-1:0]  upper_r;
  logic [tsc_pkg::ValW-1:0]  lower_r;

  logic                      out_load;
  logic                      in_xfer;
  tsc_pkg::sp_ctl_t          sp_ctl;
  tsc_pkg::sp_val_t          sp_val;
  logic [tsc_pkg::ValW-1:0]  fahr;
  logic                      cool;
  logic                      heat;

  // pipeline flow control
  assign out_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || out_load;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= tsc_pkg::UpperLimitRst;
      lower_r <= tsc_pkg::LowerLimitRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsc_pkg::CFG_UPPER_LIMIT: upper_r <= cfg_data;
        tsc_pkg::CFG_LOWER_LIMIT: lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // setpoint state, committed when the sample moves to the result register
  assign sp_ctl.commit      = out_load;
  assign sp_ctl.enc_a       = s1_data_r.enc_a;
  assign sp_ctl.enc_b       = s1_data_r.enc_b;
  assign sp_ctl.low_button  = s1_data_r.low_button;
  assign sp_ctl.high_button = s1_data_r.high_button;

  tsc_setpoint u_setpoint (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (sp_ctl),
    .upper_limit (upper_r),
    .lower_limit (lower_r),
    .val         (sp_val)
  );

  tsc_temp u_temp (
    .temp_raw        (s1_data_r.temp_raw),
    .high_value      (sp_val.high_value),
    .low_value       (sp_val.low_value),
    .temp_fahrenheit (fahr),
    .cool_on         (cool),
    .heat_on         (heat)
  );

  // result assembly
  always_comb begin
    out_data_nxt.temp_fahrenheit = fahr;
    out_data_nxt.high_value      = sp_val.high_value;
    out_data_nxt.low_value       = sp_val.low_value;
    out_data_nxt.cool_on         = cool;
    out_data_nxt.heat_on         = heat;
    out_data_nxt.adjusting_high  = sp_val.adjusting_high;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // both stages full and output stalled blocks the input
  `TSC_ASSERT_IMP(a_full, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  // a pending sample moves on whenever the result register frees up
  `TSC_ASSERT_NXT(a_move, s1_valid_r && !out_valid_r, out_valid_r)
  // reported demands never ask for cooling and heating at once
  `TSC_ASSERT_IMP(a_demand, out_valid_r, !(out_data_r.cool_on && out_data_r.heat_on))

endmodule
`default_nettype wire

/* test/tb_thermostat_setpoint_controller.sv */
`timescale 1ns / 100ps

module tb_thermostat_setpoint_controller;
  import tsc_pkg::*;

  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 124;
  localparam int QuietLimit    = 400;
  localparam int MaxReports    = 200;

  // how the two sides idle during one stretch of traffic
  typedef enum int {
    PACE_BOTH,
    PACE_NONE,
    PACE_SEND,
    PACE_RECV
  } pace_t;

  // one row of the directed sequence
  typedef struct {
    in_item_t  sample;
    bit        typed;
    out_item_t want;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [ValW-1:0]     cfg_data;

  // typed-in expectation that travels with the sample on the input channel
  bit                  in_typed;
  out_item_t           in_typed_want;

  // predicted block state and limits
  logic [7:0]          lim_upper = UpperLimitRst;
  logic [7:0]          lim_lower = LowerLimitRst;
  logic [1:0]          enc_phase = 2'd0;
  logic [7:0]          set_high  = HighSetRst;
  logic [7:0]          set_low   = LowSetRst;
  logic                sel_high  = 1'b1;

  out_item_t           pending_results[$];
  row_t                dir_rows[$];
  pace_t               pace_mode = PACE_BOTH;
  int                  errors = 0;
  int                  quiet_cycles = 0;
  bit                  out_took = 1'b1;

  thermostat_setpoint_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // next setpoints and demands for one sample; advances the predicted state
  function automatic out_item_t thermostat_next(in_item_t s);
    logic [1:0] ph;
    int         step;
    int         v;
    int         f;
    out_item_t  r;
    if (!s.low_button) sel_high = 1'b0;
    else if (!s.high_button) sel_high = 1'b1;
    // gray decode of (a, b): 00 -> 0, 10 -> 1, 11 -> 2, 01 -> 3
    ph = {s.enc_b, s.enc_a ^ s.enc_b};
    step = 0;
    if (ph == 2'(enc_phase + 2'd1)) step = 1;
    else if (ph == 2'(enc_phase - 2'd1)) step = -1;
    // a two-phase jump leaves phase and setpoints alone
    if (step != 0) begin
      enc_phase = ph;
      if (sel_high) begin
        v = int'(set_high) + step;
        if (v > int'(lim_upper)) v = int'(lim_upper);
        if (v < int'(set_low)) v = int'(set_low);
        set_high = v[7:0];
      end else begin
        v = int'(set_low) + step;
        if (v < int'(lim_lower)) v = int'(lim_lower);
        if (v > int'(set_high)) v = int'(set_high);
        set_low = v[7:0];
      end
    end
    f = (9 * int'(s.temp_raw)) / 80 + 32;
    if (f > 255) f = 255;
    r.temp_fahrenheit = f[7:0];
    r.high_value      = set_high;
    r.low_value       = set_low;
    r.cool_on         = int'(set_high) < f;
    r.heat_on         = int'(set_low) > f;
    r.adjusting_high  = sel_high;
    return r;
  endfunction

  // mostly single encoder steps in one direction, temperatures half the time near the setpoints
  function automatic in_item_t random_sample(bit up);
    in_item_t   s;
    logic [1:0] tgt;
    int         pick;
    int         tf;
    int         raw;
    pick = $urandom_range(0, 99);
    if (pick < 70) tgt = up ? 2'(enc_phase + 2'd1) : 2'(enc_phase - 2'd1);
    else if (pick < 80) tgt = enc_phase;
    else if (pick < 90) tgt = 2'(enc_phase + 2'd2);
    else tgt = 2'($urandom_range(0, 3));
    s.enc_b = tgt[1];
    s.enc_a = tgt[1] ^ tgt[0];
    // buttons mostly released, now and then one or both pressed
    pick = $urandom_range(0, 99);
    s.low_button  = !((pick >= 90 && pick < 94) || pick >= 98);
    s.high_button = !(pick >= 94);
    pick = $urandom_range(0, 3);
    if (pick < 2) begin
      s.temp_raw = 11'($urandom_range(0, 2047));
    end else begin
      tf = (pick == 2) ? int'(set_high) : int'(set_low);
      tf = tf + int'($urandom_range(0, 2)) - 1;
      if (tf < 32) begin
        s.temp_raw = 11'($urandom_range(0, 8));
      end else begin
        raw = ((tf - 32) * 80 + 8) / 9;
        if (raw > 2047) raw = 2047;
        s.temp_raw = raw[10:0];
      end
    end
    return s;
  endfunction

  function automatic int sender_gap();
    if (pace_mode == PACE_BOTH || pace_mode == PACE_SEND) return int'($urandom_range(0, 11));
    return 0;
  endfunction

  function automatic int receiver_stall();
    if (pace_mode == PACE_BOTH || pace_mode == PACE_RECV) return int'($urandom_range(0, 11));
    return 0;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // one sample transfer, called and returning at a falling edge
  task automatic drive_sample(in_item_t s, bit typed, out_item_t want);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data       <= s;
    in_typed      <= typed;
    in_typed_want <= want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // register write; the caller drops cfg_valid after the last one
  task automatic cfg_write(cfg_idx_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic add_row(in_item_t s, bit typed, out_item_t want);
    row_t r;
    r.sample = s;
    r.typed  = typed;
    r.want   = want;
    dir_rows.push_back(r);
  endtask

  // transfers on all channels: predict on input, compare on output
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_took = 1'b1;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("temp_fahrenheit", want.temp_fahrenheit, out_data.temp_fahrenheit);
          check_field("high_value", want.high_value, out_data.high_value);
          check_field("low_value", want.low_value, out_data.low_value);
          check_field("cool_on", want.cool_on, out_data.cool_on);
          check_field("heat_on", want.heat_on, out_data.heat_on);
          check_field("adjusting_high", want.adjusting_high, out_data.adjusting_high);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_UPPER_LIMIT) lim_upper = cfg_data;
        else if (cfg_index == CFG_LOWER_LIMIT) lim_lower = cfg_data;
      end
      if (in_valid && in_ready) begin
        want = thermostat_next(in_data);
        if (in_typed) want = in_typed_want;
        pending_results.push_back(want);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: fresh stall drawn after each transfer
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_took) begin
        hold = receiver_stall();
        out_took = 1'b0;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    logic [7:0] up;
    logic [7:0] lo;
    bit         dir;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    in_typed      = 1'b0;
    in_typed_want = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_UPPER_LIMIT;
    cfg_data      = '0;

    // fields: enc_a, enc_b, low_button, high_button, temp_raw
    // after reset: cold and hot extremes, high step held at the upper limit
    add_row('{1'b0, 1'b0, 1'b1, 1'b1, 11'd0}, 1'b1,
            '{8'd32, 8'd100, 8'd40, 1'b0, 1'b1, 1'b1});
    add_row('{1'b0, 1'b0, 1'b1, 1'b1, 11'd2047}, 1'b1,
            '{8'd255, 8'd100, 8'd40, 1'b1, 1'b0, 1'b1});
    add_row('{1'b1, 1'b0, 1'b1, 1'b1, 11'd1000}, 1'b1,
            '{8'd144, 8'd100, 8'd40, 1'b1, 1'b0, 1'b1});
    // low selected, steps up and down, a two-phase jump in between
    add_row('{1'b1, 1'b1, 1'b0, 1'b1, 11'd500}, 1'b0, '0);
    add_row('{1'b0, 1'b1, 1'b1, 1'b1, 11'd700}, 1'b0, '0);
    add_row('{1'b0, 1'b0, 1'b1, 1'b1, 11'd900}, 1'b0, '0);
    add_row('{1'b0, 1'b1, 1'b1, 1'b1, 11'd300}, 1'b0, '0);
    add_row('{1'b1, 1'b0, 1'b1, 1'b1, 11'd1100}, 1'b0, '0);
    add_row('{1'b1, 1'b1, 1'b1, 1'b1, 11'd1200}, 1'b0, '0);
    // both buttons pressed, pins unchanged
    add_row('{1'b1, 1'b1, 1'b0, 1'b0, 11'd1300}, 1'b0, '0);
    // back to high, steps against the limit
    add_row('{1'b0, 1'b1, 1'b1, 1'b0, 11'd1400}, 1'b0, '0);
    add_row('{1'b1, 1'b1, 1'b1, 1'b1, 11'd1500}, 1'b0, '0);
    add_row('{1'b0, 1'b1, 1'b1, 1'b1, 11'd1600}, 1'b0, '0);
    // conversion around saturation
    add_row('{1'b0, 1'b0, 1'b1, 1'b1, 11'd1982}, 1'b0, '0);
    add_row('{1'b0, 1'b0, 1'b1, 1'b1, 11'd1983}, 1'b0, '0);
    add_row('{1'b0, 1'b0, 1'b1, 1'b1, 11'd1992}, 1'b0, '0);
    add_row('{1'b0, 1'b0, 1'b1, 1'b1, 11'd80}, 1'b0, '0);
    add_row('{1'b0, 1'b0, 1'b0, 1'b1, 11'd1777}, 1'b0, '0);
    add_row('{1'b1, 1'b1, 1'b1, 1'b1, 11'h2aa}, 1'b0, '0);
    add_row('{1'b0, 1'b1, 1'b1, 1'b1, 11'h555}, 1'b0, '0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // random traffic under a sequence of limit settings
    for (int p = 0; p < NumPhases; p++) begin
      pace_mode = pace_t'(p % 4);
      case (p)
        0: begin up = 8'd255; lo = 8'd0;   end
        1: begin up = 8'd0;   lo = 8'd0;   end
        2: begin up = 8'd255; lo = 8'd255; end
        3: begin up = 8'd0;   lo = 8'd255; end
        4: begin up = UpperLimitRst; lo = LowerLimitRst; end
        5: begin up = 8'd130; lo = 8'd120; end
        6: begin up = 8'd60;  lo = 8'd70;  end
        default: begin
          up = 8'($urandom_range(0, 255));
          lo = 8'($urandom_range(0, 255));
        end
      endcase
      // one phase rewrites only the lower limit
      if (p != 7) cfg_write(CFG_UPPER_LIMIT, up);
      cfg_write(CFG_LOWER_LIMIT, lo);
      cfg_valid <= 1'b0;
      dir = 1'($urandom_range(0, 1));
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if ($urandom_range(0, 39) == 0) dir = !dir;
        drive_sample(random_sample(dir), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
